// File: hw/rtl/rmsl_pkg.sv
`default_nettype none

package rmsl_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int MAG_W       = 15;
    localparam int SQ_W        = 29;
    localparam int SUM_W       = 40;
    localparam int LEVEL_W     = 15;
    localparam int SCALED_W    = 16;
    localparam int WEIGHT_W    = 16;
    localparam int FS_W        = 15;
    localparam int ROOT_IN_W   = 30;
    localparam int ROOT_REM_W  = 16;
    localparam int PROD_W      = 32;
    localparam int STEP_W      = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = 1;
    localparam int QLEVEL_W    = 2;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 48;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd4588;
    localparam logic [FS_W-1:0]     FS_RESET     = 15'd5571;
    localparam logic [SUM_W-1:0]    SUM_MAX      = '1;

    localparam logic [STEP_W-1:0] DIV_LAST   = 6'd39;
    localparam logic [STEP_W-1:0] ROOT_LAST  = 6'd14;
    localparam logic [STEP_W-1:0] SCALE_LAST = 6'd15;

    typedef enum logic [0:0] {
        REG_SMOOTHING_WEIGHT = 1'b0,
        REG_FULL_SCALE       = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_ROOT,
        B_MUL_OLD,
        B_MUL_NEW,
        B_BLEND,
        B_SCALE,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        logic [QLEVEL_W-1:0] level;
        logic                not_empty;
    } q_status_t;

    // Square of floor(s/2); the arithmetic shift rounds toward minus infinity.
    function automatic logic [SQ_W-1:0] halved_square(input logic signed [SAMPLE_W-1:0] s);
        logic signed [SAMPLE_W-1:0] h;
        logic [SAMPLE_W-1:0]        mag;
        h   = s >>> 1;
        mag = h[SAMPLE_W-1] ? SAMPLE_W'(-h) : SAMPLE_W'(h);
        return SQ_W'(mag[MAG_W-1:0]) * SQ_W'(mag[MAG_W-1:0]);
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rmsl_front.sv
`default_nettype none

module rmsl_front #(
    parameter int MAX_FRAMES = 1024,
    parameter int CNT_W      = 11
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] left_sample, [31:16] right_sample
    input  wire  [rmsl_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  wire                               s_axis_tlast,
    input  rmsl_pkg::q_status_t               q_status,
    output logic                              push,
    output logic [rmsl_pkg::SUM_W-1:0]        push_sum,
    output logic [CNT_W-1:0]                  push_count
);
    import rmsl_pkg::*;

    logic              accept;
    logic              s1_valid_reg;
    logic              s1_eob_reg;
    logic [SQ_W-1:0]   s1_sq_l_reg;
    logic [SQ_W-1:0]   s1_sq_r_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  sum_next;
    logic [CNT_W-1:0]  count_next;
    logic              room;

    // An end frame held in the square stage will need a queue slot next cycle.
    assign s_axis_tready = ((QLEVEL_W+1)'(q_status.level)
                           + (QLEVEL_W+1)'(s1_valid_reg & s1_eob_reg))
                           < (QLEVEL_W+1)'(QUEUE_DEPTH);
    assign accept = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_eob_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                s1_eob_reg <= s_axis_tlast;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sq_l_reg <= halved_square(s_axis_tdata[SAMPLE_W-1:0]);
            s1_sq_r_reg <= halved_square(s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]);
        end
    end

    always_comb
    begin
        room     = count_reg < CNT_W'(MAX_FRAMES);
        sum_wide = {1'b0, sum_reg} + (SUM_W+1)'(s1_sq_l_reg) + (SUM_W+1)'(s1_sq_r_reg);
        if (room)
        begin
            sum_next   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else
        begin
            sum_next   = sum_reg;
            count_next = count_reg;
        end
    end

    assign push       = s1_valid_reg & s1_eob_reg;
    assign push_sum   = sum_next;
    assign push_count = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            if (s1_eob_reg)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
            end
            else
            begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rmsl_queue.sv
`default_nettype none

module rmsl_queue #(
    parameter int CNT_W = 11
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          push,
    input  wire  [rmsl_pkg::SUM_W-1:0]   push_sum,
    input  wire  [CNT_W-1:0]             push_count,
    input  wire                          pop,
    output rmsl_pkg::q_status_t          q_status,
    output logic [rmsl_pkg::SUM_W-1:0]   head_sum,
    output logic [CNT_W-1:0]             head_count
);
    import rmsl_pkg::*;

    logic [SUM_W-1:0]    sum_mem [QUEUE_DEPTH];
    logic [CNT_W-1:0]    cnt_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [QLEVEL_W-1:0] level_reg;
    logic [QLEVEL_W-1:0] level_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            sum_mem[wr_ptr_reg] <= push_sum;
            cnt_mem[wr_ptr_reg] <= push_count;
        end
    end

    always_comb
    begin
        level_next = level_reg;
        if (push && !pop)
        begin
            level_next = QLEVEL_W'(level_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            level_next = QLEVEL_W'(level_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= PTR_W'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= PTR_W'(rd_ptr_reg + 1'b1);
            end
            level_reg <= level_next;
        end
    end

    assign head_sum           = sum_mem[rd_ptr_reg];
    assign head_count         = cnt_mem[rd_ptr_reg];
    assign q_status.level     = level_reg;
    assign q_status.not_empty = level_reg != '0;

endmodule

`default_nettype wire

// File: hw/rtl/rmsl_back.sv
`default_nettype none

module rmsl_back #(
    parameter int CNT_W = 11
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  rmsl_pkg::q_status_t             q_status,
    input  wire  [rmsl_pkg::SUM_W-1:0]      head_sum,
    input  wire  [CNT_W-1:0]                head_count,
    output logic                            pop,
    input  wire  [rmsl_pkg::WEIGHT_W-1:0]   weight,
    input  wire  [rmsl_pkg::FS_W-1:0]       full_scale,
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // [14:0] rms_level, [29:15] smoothed_level, [45:30] scaled_level, [47:46] zero
    output logic [rmsl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import rmsl_pkg::*;

    localparam int DVW = CNT_W + 1;

    back_state_t state_reg, state_next;
    logic [STEP_W-1:0]     step_reg;

    logic [SUM_W-1:0]      quo_reg;
    logic [DVW-1:0]        drem_reg;
    logic [DVW-1:0]        divisor_reg;
    logic                  zero_cnt_reg;
    logic [ROOT_IN_W-1:0]  root_in_reg;
    logic [ROOT_REM_W-1:0] rrem_reg;
    logic [LEVEL_W-1:0]    root_reg;
    logic [LEVEL_W-1:0]    rms_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [PROD_W-1:0]     acc_reg;
    logic [LEVEL_W-1:0]    smoothed_reg;
    logic [FS_W-1:0]       srem_reg;
    logic [SCALED_W-1:0]   squo_reg;
    logic                  m_valid_reg;
    logic [LEVEL_W-1:0]    out_rms_reg;
    logic [LEVEL_W-1:0]    out_smoothed_reg;
    logic [SCALED_W-1:0]   out_scaled_reg;

    logic [DVW:0]          d_sh;
    logic [DVW:0]          d_diff;
    logic                  d_ge;
    logic [ROOT_REM_W+1:0] r_sh;
    logic [ROOT_REM_W+1:0] r_trial;
    logic [ROOT_REM_W+1:0] r_diff;
    logic                  r_ge;
    logic [WEIGHT_W:0]     mul_a;
    logic [LEVEL_W-1:0]    mul_b;
    logic [PROD_W-1:0]     mul_p;
    logic [PROD_W:0]       blend;
    logic [LEVEL_W-1:0]    blend_lvl;
    logic                  sat;
    logic [FS_W:0]         s_sh;
    logic [FS_W:0]         s_diff;
    logic                  s_ge;
    logic                  out_free;
    logic                  out_load;

    // Restoring divider step for the mean square: one quotient bit a cycle.
    always_comb
    begin
        d_sh   = {drem_reg, quo_reg[SUM_W-1]};
        d_diff = d_sh - {1'b0, divisor_reg};
        d_ge   = d_sh >= {1'b0, divisor_reg};
    end

    // Digit-by-digit square root: two radicand bits, one root bit a cycle.
    always_comb
    begin
        r_sh    = {rrem_reg, root_in_reg[ROOT_IN_W-1:ROOT_IN_W-2]};
        r_trial = {1'b0, root_reg, 2'b01};
        r_diff  = r_sh - r_trial;
        r_ge    = r_sh >= r_trial;
    end

    always_comb
    begin
        mul_p     = PROD_W'({15'd0, mul_a} * {17'd0, mul_b});
        blend     = {1'b0, acc_reg} + {1'b0, prod_reg};
        blend_lvl = blend[LEVEL_W+15:16];
        sat       = (full_scale == '0) || (blend_lvl >= full_scale);
        s_sh      = {srem_reg, 1'b0};
        s_diff    = s_sh - {1'b0, full_scale};
        s_ge      = s_sh >= {1'b0, full_scale};
        out_free  = !m_valid_reg || m_axis_tready;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_status.not_empty)
                begin
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (step_reg == DIV_LAST)
                begin
                    state_next = B_ROOT;
                end
            end
            B_ROOT:
            begin
                if (step_reg == ROOT_LAST)
                begin
                    state_next = B_MUL_OLD;
                end
            end
            B_MUL_OLD: state_next = B_MUL_NEW;
            B_MUL_NEW: state_next = B_BLEND;
            B_BLEND:   state_next = sat ? B_EMIT : B_SCALE;
            B_SCALE:
            begin
                if (step_reg == SCALE_LAST)
                begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        out_load = 1'b0;
        mul_a    = {1'b0, weight};
        mul_b    = rms_reg;
        unique case (state_reg)
            B_IDLE:    pop = q_status.not_empty;
            B_MUL_OLD:
            begin
                mul_a = (WEIGHT_W+1)'(17'h10000 - {1'b0, weight});
                mul_b = smoothed_reg;
            end
            B_EMIT:    out_load = out_free;
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            step_reg     <= '0;
            smoothed_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= (state_next != state_reg) ? '0 : STEP_W'(step_reg + 1'b1);
            if (state_reg == B_BLEND)
            begin
                smoothed_reg <= blend_lvl;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    quo_reg      <= head_sum;
                    drem_reg     <= '0;
                    divisor_reg  <= {head_count, 1'b0};
                    zero_cnt_reg <= head_count == '0;
                end
            end
            B_DIV:
            begin
                quo_reg  <= {quo_reg[SUM_W-2:0], d_ge};
                drem_reg <= d_ge ? d_diff[DVW-1:0] : d_sh[DVW-1:0];
                if (step_reg == DIV_LAST)
                begin
                    // The mean square never exceeds 2^28, so its low bits carry it all.
                    root_in_reg <= zero_cnt_reg ? '0 : {quo_reg[ROOT_IN_W-2:0], d_ge};
                    rrem_reg    <= '0;
                    root_reg    <= '0;
                end
            end
            B_ROOT:
            begin
                root_in_reg <= {root_in_reg[ROOT_IN_W-3:0], 2'b00};
                rrem_reg    <= r_ge ? r_diff[ROOT_REM_W-1:0] : r_sh[ROOT_REM_W-1:0];
                root_reg    <= {root_reg[LEVEL_W-2:0], r_ge};
                if (step_reg == ROOT_LAST)
                begin
                    rms_reg <= {root_reg[LEVEL_W-2:0], r_ge};
                end
            end
            B_MUL_OLD:
            begin
                prod_reg <= mul_p;
            end
            B_MUL_NEW:
            begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            B_BLEND:
            begin
                srem_reg <= blend_lvl;
                squo_reg <= '1;
            end
            B_SCALE:
            begin
                srem_reg <= s_ge ? s_diff[FS_W-1:0] : s_sh[FS_W-1:0];
                squo_reg <= {squo_reg[SCALED_W-2:0], s_ge};
            end
            B_EMIT:
            begin
                if (out_load)
                begin
                    out_rms_reg      <= rms_reg;
                    out_smoothed_reg <= smoothed_reg;
                    out_scaled_reg   <= squo_reg;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, out_scaled_reg, out_smoothed_reg, out_rms_reg};

endmodule

`default_nettype wire

// File: hw/rtl/rms_level_meter_smoothed_unit.sv
// Frames are taken one per cycle while tready is high; squares are registered
// at the transfer and summed in the cycle after it. Each buffer passes through
// the bit-serial 40-step mean divider, the 15-step square root and the 16-step
// scaling divider (skipped when the scaled level saturates), one buffer at a time.
// A two-entry queue holds finished buffer sums; tready drops while it is full,
// or when a pending end frame will fill it. rst_n is asynchronous: it clears
// sums, counts, smoothed level and queue, and loads the register defaults.
`default_nettype none

module rms_level_meter_smoothed_unit #(
    parameter int MAX_FRAMES = 1024
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] left_sample, [31:16] right_sample
    input  wire  [rmsl_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  wire                               s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // [14:0] rms_level, [29:15] smoothed_level, [45:30] scaled_level, [47:46] zero
    output logic [rmsl_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  wire                               cfg_we,
    input  wire                               cfg_index,
    input  wire  [rmsl_pkg::WEIGHT_W-1:0]     cfg_data
);
    import rmsl_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAMES + 1);

    logic [WEIGHT_W-1:0] weight_reg;
    logic [FS_W-1:0]     full_scale_reg;
    q_status_t           q_status;
    logic                push;
    logic [SUM_W-1:0]    push_sum;
    logic [CNT_W-1:0]    push_count;
    logic                pop;
    logic [SUM_W-1:0]    head_sum;
    logic [CNT_W-1:0]    head_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg     <= WEIGHT_RESET;
            full_scale_reg <= FS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_SMOOTHING_WEIGHT: weight_reg     <= cfg_data;
                REG_FULL_SCALE:       full_scale_reg <= cfg_data[FS_W-1:0];
                default:              weight_reg     <= weight_reg;
            endcase
        end
    end

    rmsl_front #(
        .MAX_FRAMES (MAX_FRAMES),
        .CNT_W      (CNT_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_status      (q_status),
        .push          (push),
        .push_sum      (push_sum),
        .push_count    (push_count)
    );

    rmsl_queue #(
        .CNT_W (CNT_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_sum   (push_sum),
        .push_count (push_count),
        .pop        (pop),
        .q_status   (q_status),
        .head_sum   (head_sum),
        .head_count (head_count)
    );

    rmsl_back #(
        .CNT_W (CNT_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .head_sum      (head_sum),
        .head_count    (head_count),
        .pop           (pop),
        .weight        (weight_reg),
        .full_scale    (full_scale_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// File: hw/rtl/rmsl_checker.sv
`default_nettype none

module rmsl_checker (
    input wire                             clk,
    input wire                             rst_n,
    input wire                             m_axis_tvalid,
    input wire                             m_axis_tready,
    input wire [rmsl_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import rmsl_pkg::*;

    logic [LEVEL_W-1:0] last_smoothed_reg;
    logic [LEVEL_W-1:0] rms_f;
    logic [LEVEL_W-1:0] smoothed_f;
    logic [LEVEL_W-1:0] lo;
    logic [LEVEL_W-1:0] hi;

    assign rms_f      = m_axis_tdata[LEVEL_W-1:0];
    assign smoothed_f = m_axis_tdata[2*LEVEL_W-1:LEVEL_W];
    assign lo         = (rms_f < last_smoothed_reg) ? rms_f : last_smoothed_reg;
    assign hi         = (rms_f < last_smoothed_reg) ? last_smoothed_reg : rms_f;

    // The smoothed level starts at zero and each transfer carries the next one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_smoothed_reg <= '0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            last_smoothed_reg <= smoothed_f;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("result offered during reset");

    a_blend_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (smoothed_f >= lo) && (smoothed_f <= hi))
        else $error("smoothed level outside previous level and new rms");

endmodule

bind rms_level_meter_smoothed_unit rmsl_checker u_rmsl_checker (.*);

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

module tb;

    import rmsl_pkg::*;

    localparam int METER_MAX_FRAMES = 1024;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               last;
    } frame_t;

    typedef struct {
        logic [14:0] rms;
        logic [14:0] smooth;
        logic [15:0] scaled;
    } level_result_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   cfg_we = 1'b0;
    logic                   cfg_index = 1'b0;
    logic [WEIGHT_W-1:0]    cfg_data = '0;

    rms_level_meter_smoothed_unit #(
        .MAX_FRAMES(METER_MAX_FRAMES)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // Shadow of the meter: registers, running sum, frame count and average.
    logic [15:0]     weight_shadow = WEIGHT_RESET;
    logic [14:0]     fs_shadow = FS_RESET;
    logic [39:0]     square_acc = '0;
    int              frame_count = 0;
    logic [14:0]     smooth_lvl = '0;

    frame_t          frames_pending[$];
    level_result_t   level_expected[$];
    int              frames_pushed = 0;
    int              frames_accepted = 0;
    int              mismatch_count = 0;

    frame_t          frame_on_bus;
    int              src_wait = 0;
    bit              src_calm = 1'b0;
    int              dst_wait = 0;
    bit              dst_calm = 1'b0;

    function automatic longint unsigned sq_of_half(input logic signed [15:0] s);
        int h;
        h = s >>> 1;
        return longint'(h * h);
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int b = 16; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if (c * c <= v)
                r = c;
        end
        return r;
    endfunction

    task automatic meter_accept(input frame_t f);
        logic [40:0]     sum_next;
        longint unsigned mean;
        longint unsigned rms;
        longint unsigned blend;
        longint unsigned quot;
        level_result_t   r;
        frames_accepted++;
        // Frames beyond the buffer limit leave the sum and the count alone.
        if (frame_count < METER_MAX_FRAMES)
        begin
            sum_next = {1'b0, square_acc} + 41'(sq_of_half(f.left)) + 41'(sq_of_half(f.right));
            square_acc = sum_next[40] ? '1 : sum_next[39:0];
            frame_count++;
        end
        if (f.last)
        begin
            rms = 0;
            if (frame_count != 0)
            begin
                mean = 64'(square_acc) / 64'(2 * frame_count);
                if (mean > 64'hFFFF_FFFF)
                    mean = 64'hFFFF_FFFF;
                rms = floor_root(mean);
            end
            blend = (64'd65536 - 64'(weight_shadow)) * 64'(smooth_lvl)
                  + 64'(weight_shadow) * rms;
            smooth_lvl = 15'(blend >> 16);
            if (fs_shadow == 0)
                r.scaled = 16'hFFFF;
            else
            begin
                quot = (64'(smooth_lvl) << 16) / 64'(fs_shadow);
                r.scaled = (quot > 64'd65535) ? 16'hFFFF : 16'(quot);
            end
            r.rms = 15'(rms);
            r.smooth = smooth_lvl;
            level_expected.insert(level_expected.size(), r);
            square_acc = '0;
            frame_count = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // Frame source.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            src_wait <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                meter_accept(frame_on_bus);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_wait != 0)
                begin
                    src_wait <= src_wait - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (frames_pending.size() != 0)
                begin
                    frame_on_bus = frames_pending.pop_front();
                    s_axis_tdata <= {frame_on_bus.right, frame_on_bus.left};
                    s_axis_tlast <= frame_on_bus.last;
                    s_axis_tvalid <= 1'b1;
                    if ($urandom_range(0, 31) == 0)
                        src_calm = !src_calm;
                    src_wait <= src_calm ? 0 : $urandom_range(0, 9);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result sink and checker.
    always @(posedge clk or negedge rst_n)
    begin : result_sink
        level_result_t want;
        int            w;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            dst_wait <= 0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            if (level_expected.size() == 0)
                report_mismatch("result with no buffer pending, rms", m_axis_tdata[14:0], 0);
            else
            begin
                want = level_expected.pop_front();
                if (m_axis_tdata[14:0] !== want.rms)
                    report_mismatch("rms_level", m_axis_tdata[14:0], want.rms);
                if (m_axis_tdata[29:15] !== want.smooth)
                    report_mismatch("smoothed_level", m_axis_tdata[29:15], want.smooth);
                if (m_axis_tdata[45:30] !== want.scaled)
                    report_mismatch("scaled_level", m_axis_tdata[45:30], want.scaled);
            end
            if ($urandom_range(0, 15) == 0)
                dst_calm = !dst_calm;
            w = dst_calm ? 0 : $urandom_range(0, 9);
            dst_wait <= w;
            m_axis_tready <= (w == 0);
        end
        else if (!m_axis_tready)
        begin
            // The wait only runs down while a result is on offer.
            if (dst_wait == 0)
                m_axis_tready <= 1'b1;
            else if (m_axis_tvalid)
                dst_wait <= dst_wait - 1;
        end
    end

    task automatic push_frame(input logic [15:0] l, input logic [15:0] r, input logic last);
        frame_t f;
        f.left = l;
        f.right = r;
        f.last = last;
        frames_pending.insert(frames_pending.size(), f);
        frames_pushed++;
    endtask

    task automatic cfg_write(input reg_index_t idx, input logic [15:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == REG_SMOOTHING_WEIGHT)
            weight_shadow = value;
        else
            fs_shadow = value[14:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Holds the test until every frame is taken and every result is back,
    // then lets the clock run on before the next setting is written.
    task automatic wait_idle();
        while (frames_accepted != frames_pushed || level_expected.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 31)) - 16'd16;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return WEIGHT_RESET;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_full_scale();
        case ($urandom_range(0, 5))
            0: return 16'd1;
            1: return 16'd16384;
            2: return 16'd0;
            default: return 16'($urandom_range(1, 16384));
        endcase
    endfunction

    initial
    begin
        int n;
        int len;
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Register defaults: extremes of both channels, zero, rounding of odd samples.
        push_frame(16'h7FFF, 16'h8000, 1'b1);
        push_frame(16'h8000, 16'h8000, 1'b1);
        push_frame(16'h0000, 16'h0000, 1'b1);
        push_frame(16'hFFFF, 16'h0001, 1'b1);
        push_frame(16'h7FFF, 16'h7FFF, 1'b0);
        push_frame(16'h8001, 16'h4000, 1'b0);
        push_frame(16'd12345, -16'sd12345, 1'b1);
        wait_idle();

        // Full weight on the new level and the smallest full scale saturate the output.
        cfg_write(REG_SMOOTHING_WEIGHT, 16'hFFFF);
        cfg_write(REG_FULL_SCALE, 16'd1);
        push_frame(16'h8000, 16'h8000, 1'b1);
        push_frame(16'd100, -16'sd100, 1'b1);
        wait_idle();

        // No weight keeps the average frozen; a zero full scale saturates.
        cfg_write(REG_SMOOTHING_WEIGHT, 16'd0);
        cfg_write(REG_FULL_SCALE, 16'd0);
        push_frame(16'h7FFF, 16'h7FFF, 1'b1);
        push_frame(16'h1234, 16'hEDCB, 1'b1);
        wait_idle();

        cfg_write(REG_SMOOTHING_WEIGHT, 16'h8000);
        cfg_write(REG_FULL_SCALE, 16'd16384);
        push_frame(16'h8000, 16'h8000, 1'b1);
        push_frame(16'h0001, 16'hFFFE, 1'b0);
        push_frame(16'hFFFE, 16'h0003, 1'b1);
        wait_idle();

        // A buffer past the frame limit, then a short one to see the sum cleared.
        cfg_write(REG_SMOOTHING_WEIGHT, WEIGHT_RESET);
        cfg_write(REG_FULL_SCALE, FS_RESET);
        for (int i = 0; i < METER_MAX_FRAMES + 60; i++)
            push_frame(pick_sample(), pick_sample(), i == METER_MAX_FRAMES + 59);
        push_frame(16'h0100, 16'hFF00, 1'b1);
        wait_idle();

        for (int p = 0; p < 6; p++)
        begin
            cfg_write(REG_SMOOTHING_WEIGHT, pick_weight());
            cfg_write(REG_FULL_SCALE, pick_full_scale());
            n = 0;
            while (n < 20)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    push_frame(pick_sample(), pick_sample(), i == len - 1);
                n += len;
            end
            // Sometimes leave a partial buffer to carry over into the next setting.
            if ($urandom_range(0, 2) == 0)
                for (int i = 0; i < 3; i++)
                    push_frame(pick_sample(), pick_sample(), 1'b0);
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("rms_level_meter_smoothed_unit test passed");
        else
            $display("rms_level_meter_smoothed_unit test failed");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("rms_level_meter_smoothed_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
hw/rtl/rmsl_pkg.sv
hw/rtl/rmsl_front.sv
hw/rtl/rmsl_queue.sv
hw/rtl/rmsl_back.sv
hw/rtl/rms_level_meter_smoothed_unit.sv
hw/rtl/rmsl_checker.sv
tb/tb.sv
